@@ rtl/oct_enc_pkg.sv @@
// oct_enc_pkg: widths, latency and pipeline control type for the octahedral normal encoder
// used by oct_enc_div and octahedral_normal_encoder_core; no dependencies
`default_nettype none

package oct_enc_pkg;

    localparam int CODE_BITS      = 16;
    localparam int COMPONENT_BITS = 16;
    localparam int PACKED_BITS    = 32;

    // |x|+|y|+|z| stays below 2^(COMPONENT_BITS+1)
    localparam int SUM_BITS = COMPONENT_BITS + 1;
    // shifted coordinate c+s and divisor 2s, both within [0, 2s]
    localparam int T_BITS   = SUM_BITS + 1;
    // (c+s)*(2^CODE_BITS-1) + s
    localparam int NUM_BITS = T_BITS + CODE_BITS + 1;

    // input register, abs, sum, numerator, one divider step per code bit, output register
    localparam int LATENCY = CODE_BITS + 5;

    typedef struct packed {
        logic valid;
        logic zero;
    } ctl_t;

endpackage

`default_nettype wire

@@ rtl/oct_enc_div.sv @@
// oct_enc_div: two-lane pipelined restoring divider, one quotient bit per stage
// shares one divisor between the x and y lanes; depends on oct_enc_pkg
`default_nettype none

module oct_enc_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire oct_enc_pkg::ctl_t                in_ctl,
    input  wire logic [oct_enc_pkg::NUM_BITS-1:0] num_x,
    input  wire logic [oct_enc_pkg::NUM_BITS-1:0] num_y,
    input  wire logic [oct_enc_pkg::T_BITS-1:0]   den,
    output oct_enc_pkg::ctl_t                     out_ctl,
    output logic [oct_enc_pkg::CODE_BITS-1:0]     quo_x,
    output logic [oct_enc_pkg::CODE_BITS-1:0]     quo_y
);
    import oct_enc_pkg::*;

    localparam int LAST = CODE_BITS - 1;

    ctl_t                 ctl_reg   [CODE_BITS];
    logic [NUM_BITS-1:0]  rem_x_reg [CODE_BITS];
    logic [NUM_BITS-1:0]  rem_y_reg [CODE_BITS];
    logic [CODE_BITS-1:0] quo_x_reg [CODE_BITS];
    logic [CODE_BITS-1:0] quo_y_reg [CODE_BITS];
    logic [T_BITS-1:0]    den_reg   [CODE_BITS];

    for (genvar k = 0; k < CODE_BITS; k++)
    begin : g_step
        localparam int BIT = CODE_BITS - 1 - k;

        ctl_t                 ctl_src;
        logic [NUM_BITS-1:0]  rem_x_src;
        logic [NUM_BITS-1:0]  rem_y_src;
        logic [CODE_BITS-1:0] quo_x_src;
        logic [CODE_BITS-1:0] quo_y_src;
        logic [T_BITS-1:0]    den_src;
        logic [NUM_BITS-1:0]  den_shift;
        logic                 ge_x;
        logic                 ge_y;
        logic [NUM_BITS-1:0]  rem_x_next;
        logic [NUM_BITS-1:0]  rem_y_next;
        logic [CODE_BITS-1:0] quo_x_next;
        logic [CODE_BITS-1:0] quo_y_next;

        if (k == 0)
        begin : g_first
            assign ctl_src   = in_ctl;
            assign rem_x_src = num_x;
            assign rem_y_src = num_y;
            assign quo_x_src = '0;
            assign quo_y_src = '0;
            assign den_src   = den;
        end
        else
        begin : g_next
            assign ctl_src   = ctl_reg[k-1];
            assign rem_x_src = rem_x_reg[k-1];
            assign rem_y_src = rem_y_reg[k-1];
            assign quo_x_src = quo_x_reg[k-1];
            assign quo_y_src = quo_y_reg[k-1];
            assign den_src   = den_reg[k-1];
        end

        assign den_shift = NUM_BITS'(den_src) << BIT;
        assign ge_x      = rem_x_src >= den_shift;
        assign ge_y      = rem_y_src >= den_shift;

        always_comb
        begin
            rem_x_next      = ge_x ? rem_x_src - den_shift : rem_x_src;
            rem_y_next      = ge_y ? rem_y_src - den_shift : rem_y_src;
            quo_x_next      = quo_x_src;
            quo_y_next      = quo_y_src;
            quo_x_next[BIT] = ge_x;
            quo_y_next[BIT] = ge_y;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else
            begin
                ctl_reg[k] <= ctl_src;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_x_reg[k] <= rem_x_next;
            rem_y_reg[k] <= rem_y_next;
            quo_x_reg[k] <= quo_x_next;
            quo_y_reg[k] <= quo_y_next;
            den_reg[k]   <= den_src;
        end
    end

    assign out_ctl = ctl_reg[LAST];
    assign quo_x   = quo_x_reg[LAST];
    assign quo_y   = quo_y_reg[LAST];

    // quotient must fit in the code width
    a_num_fits: assert property (@(posedge clk) disable iff (!rst_n)
        in_ctl.valid && !in_ctl.zero |->
            (num_x < (NUM_BITS'(den) << CODE_BITS)) && (num_y < (NUM_BITS'(den) << CODE_BITS)))
        else $error("numerator too large for code width");

    a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_ctl.valid && !out_ctl.zero |->
            (rem_x_reg[LAST] < NUM_BITS'(den_reg[LAST]))
            && (rem_y_reg[LAST] < NUM_BITS'(den_reg[LAST])))
        else $error("final remainder not below divisor");

    a_valid_delay: assert property (@(posedge clk) disable iff (!rst_n)
        out_ctl.valid |-> $past(in_ctl.valid, CODE_BITS))
        else $error("divider valid lost or invented");

endmodule

`default_nettype wire

@@ rtl/octahedral_normal_encoder_core.sv @@
// octahedral_normal_encoder_core: top level of the octahedral normal encoder
// abs/sum/fold/numerator stages feeding oct_enc_div; depends on oct_enc_pkg, oct_enc_div
//
// usage:
//   a transaction is taken at each rising edge with start high and busy low;
//   busy stays low, so one vector may be issued every cycle
//   comp_x, comp_y, comp_z are signed components of any scale
//   each result shows on packed_code / zero_vector for exactly one cycle,
//   marked by done; y code in bits 31..16, x code in bits 15..0
//   a zero vector gives packed_code 0 with zero_vector high
// path from the accepting edge to the result: input register, abs, sum and fold,
//   numerator, 16 divider steps, output register
// throughput: one transaction per cycle; the divider is a 16-stage pipeline,
//   one quotient bit per stage, shared by the x and y lanes
// reset: rst_n clears all pipeline valid bits; transactions in flight are dropped
// the receiver cannot stall, so results leave in issue order with fixed latency
`default_nettype none

module octahedral_normal_encoder_core (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         start,
    output logic                                              busy,
    input  wire logic signed [oct_enc_pkg::COMPONENT_BITS-1:0] comp_x,
    input  wire logic signed [oct_enc_pkg::COMPONENT_BITS-1:0] comp_y,
    input  wire logic signed [oct_enc_pkg::COMPONENT_BITS-1:0] comp_z,
    output logic                                              done,
    output logic [oct_enc_pkg::PACKED_BITS-1:0]               packed_code,
    output logic                                              zero_vector
);
    import oct_enc_pkg::*;

    localparam int MSB = COMPONENT_BITS - 1;

    // input stage
    logic                             in_valid_reg;
    logic signed [COMPONENT_BITS-1:0] x_reg;
    logic signed [COMPONENT_BITS-1:0] y_reg;
    logic signed [COMPONENT_BITS-1:0] z_reg;

    // abs stage
    logic                             abs_valid_reg;
    logic        [COMPONENT_BITS-1:0] ax_reg;
    logic        [COMPONENT_BITS-1:0] ay_reg;
    logic        [COMPONENT_BITS-1:0] az_reg;
    logic signed [COMPONENT_BITS-1:0] xs_reg;
    logic signed [COMPONENT_BITS-1:0] ys_reg;
    logic                             x_pos_reg;
    logic                             x_neg_reg;
    logic                             y_pos_reg;
    logic                             y_neg_reg;
    logic                             z_neg_reg;
    logic        [COMPONENT_BITS-1:0] ax_next;
    logic        [COMPONENT_BITS-1:0] ay_next;
    logic        [COMPONENT_BITS-1:0] az_next;

    // sum and fold stage
    logic                sum_valid_reg;
    logic [SUM_BITS-1:0] s_reg;
    logic [T_BITS-1:0]   tx_reg;
    logic [T_BITS-1:0]   ty_reg;
    logic [SUM_BITS-1:0] s_next;
    logic [T_BITS-1:0]   s_wide;
    logic [T_BITS-1:0]   tx_next;
    logic [T_BITS-1:0]   ty_next;

    // numerator stage
    ctl_t                num_ctl_reg;
    logic [NUM_BITS-1:0] num_x_reg;
    logic [NUM_BITS-1:0] num_y_reg;
    logic [T_BITS-1:0]   den_reg;

    // divider outputs
    ctl_t                 div_ctl;
    logic [CODE_BITS-1:0] div_qx;
    logic [CODE_BITS-1:0] div_qy;
    logic [63:0]          pack_wide;

    // output stage
    logic                   done_reg;
    logic [PACKED_BITS-1:0] packed_code_reg;
    logic                   zero_vector_reg;

    assign busy = 1'b0;

    always_comb
    begin
        ax_next = x_reg[MSB] ? COMPONENT_BITS'(-x_reg) : COMPONENT_BITS'(x_reg);
        ay_next = y_reg[MSB] ? COMPONENT_BITS'(-y_reg) : COMPONENT_BITS'(y_reg);
        az_next = z_reg[MSB] ? COMPONENT_BITS'(-z_reg) : COMPONENT_BITS'(z_reg);
    end

    always_comb
    begin
        s_next = SUM_BITS'(ax_reg) + SUM_BITS'(ay_reg) + SUM_BITS'(az_reg);
        s_wide = T_BITS'(s_next);
        if (z_neg_reg)
        begin
            // fold onto upper hemisphere, using the unfolded magnitudes
            if (x_pos_reg)
                tx_next = (s_wide << 1) - T_BITS'(ay_reg);
            else if (x_neg_reg)
                tx_next = T_BITS'(ay_reg);
            else
                tx_next = s_wide;
            if (y_pos_reg)
                ty_next = (s_wide << 1) - T_BITS'(ax_reg);
            else if (y_neg_reg)
                ty_next = T_BITS'(ax_reg);
            else
                ty_next = s_wide;
        end
        else
        begin
            tx_next = s_wide + {{(T_BITS-COMPONENT_BITS){xs_reg[MSB]}}, xs_reg};
            ty_next = s_wide + {{(T_BITS-COMPONENT_BITS){ys_reg[MSB]}}, ys_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            abs_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            num_ctl_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg      <= start && !busy;
            abs_valid_reg     <= in_valid_reg;
            sum_valid_reg     <= abs_valid_reg;
            num_ctl_reg.valid <= sum_valid_reg;
            num_ctl_reg.zero  <= (s_reg == '0);
            done_reg          <= div_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            x_reg <= comp_x;
            y_reg <= comp_y;
            z_reg <= comp_z;
        end
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        az_reg    <= az_next;
        xs_reg    <= x_reg;
        ys_reg    <= y_reg;
        x_pos_reg <= !x_reg[MSB] && (x_reg != '0);
        x_neg_reg <= x_reg[MSB];
        y_pos_reg <= !y_reg[MSB] && (y_reg != '0);
        y_neg_reg <= y_reg[MSB];
        z_neg_reg <= z_reg[MSB];
        s_reg     <= s_next;
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        // t*(2^CODE_BITS-1) + s
        num_x_reg <= (NUM_BITS'(tx_reg) << CODE_BITS) - NUM_BITS'(tx_reg) + NUM_BITS'(s_reg);
        num_y_reg <= (NUM_BITS'(ty_reg) << CODE_BITS) - NUM_BITS'(ty_reg) + NUM_BITS'(s_reg);
        den_reg   <= T_BITS'(s_reg) << 1;
    end

    oct_enc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (num_ctl_reg),
        .num_x   (num_x_reg),
        .num_y   (num_y_reg),
        .den     (den_reg),
        .out_ctl (div_ctl),
        .quo_x   (div_qx),
        .quo_y   (div_qy)
    );

    assign pack_wide = (64'(div_qy) << CODE_BITS) | 64'(div_qx);

    always_ff @(posedge clk)
    begin
        packed_code_reg <= div_ctl.zero ? '0 : pack_wide[PACKED_BITS-1:0];
        zero_vector_reg <= div_ctl.zero;
    end

    assign done        = done_reg;
    assign packed_code = packed_code_reg;
    assign zero_vector = zero_vector_reg;

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching transaction");

    a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_vector |-> packed_code == '0)
        else $error("zero vector with nonzero code");

endmodule

`default_nettype wire

@@ verif/octahedral_normal_encoder_core_tb.sv @@
// octahedral_normal_encoder_core_tb: self-checking testbench for the octahedral normal encoder
// directed table then random vectors, checked against fixed codes or a built-in predictor
// depends on oct_enc_pkg and octahedral_normal_encoder_core
module octahedral_normal_encoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import oct_enc_pkg::*;

    localparam int RANDOM_ITEMS   = 1450;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIRECTED_ROWS  = 24;

    typedef logic signed [COMPONENT_BITS-1:0] comp_t;

    typedef struct packed {
        logic [PACKED_BITS-1:0] code;
        logic                   zero;
    } normal_code_t;

    typedef struct packed {
        comp_t                  x;
        comp_t                  y;
        comp_t                  z;
        logic                   fixed;
        logic [PACKED_BITS-1:0] code;
        logic                   zero;
    } vector_row_t;

    // fixed rows carry a hand-derived code, the rest go through the predictor
    vector_row_t vector_table [0:DIRECTED_ROWS-1] = '{
        '{16'sd0,      16'sd0,      16'sd0,      1'b1, 32'h0000_0000, 1'b1},
        '{16'sd32767,  16'sd0,      16'sd0,      1'b1, 32'h8000_FFFF, 1'b0},
        '{-16'sd32768, 16'sd0,      16'sd0,      1'b1, 32'h8000_0000, 1'b0},
        '{16'sd0,      16'sd32767,  16'sd0,      1'b1, 32'hFFFF_8000, 1'b0},
        '{16'sd0,      -16'sd32768, 16'sd0,      1'b1, 32'h0000_8000, 1'b0},
        '{16'sd0,      16'sd0,      16'sd32767,  1'b1, 32'h8000_8000, 1'b0},
        '{16'sd0,      16'sd0,      -16'sd32768, 1'b1, 32'h8000_8000, 1'b0},
        '{16'sd0,      16'sd0,      16'sd1,      1'b1, 32'h8000_8000, 1'b0},
        '{16'sd0,      16'sd0,      -16'sd1,     1'b1, 32'h8000_8000, 1'b0},
        '{16'sd1,      16'sd0,      16'sd0,      1'b1, 32'h8000_FFFF, 1'b0},
        '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, 32'h0,         1'b0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 32'h0,         1'b0},
        '{16'sd32767,  -16'sd32768, -16'sd1,     1'b0, 32'h0,         1'b0},
        '{-16'sd32768, 16'sd32767,  -16'sd32768, 1'b0, 32'h0,         1'b0},
        '{16'sd1,      16'sd1,      16'sd0,      1'b0, 32'h0,         1'b0},
        '{16'sd1,      -16'sd1,     16'sd0,      1'b0, 32'h0,         1'b0},
        '{16'sd3,      16'sd0,      -16'sd5,     1'b0, 32'h0,         1'b0},
        '{16'sd0,      -16'sd7,     -16'sd2,     1'b0, 32'h0,         1'b0},
        '{-16'sd1,     16'sd2,      -16'sd3,     1'b0, 32'h0,         1'b0},
        '{16'sd1,      16'sd1,      16'sd1,      1'b0, 32'h0,         1'b0},
        '{16'sd5,      -16'sd3,     -16'sd12345, 1'b0, 32'h0,         1'b0},
        '{16'sd12345,  -16'sd23456, 16'sd7,      1'b0, 32'h0,         1'b0},
        '{-16'sd1,     -16'sd1,     -16'sd1,     1'b0, 32'h0,         1'b0},
        '{16'sd0,      16'sd1,      -16'sd1,     1'b0, 32'h0,         1'b0}
    };

    logic  clk = 1'b0;
    logic  rst_n;
    logic  start;
    logic  busy;
    comp_t comp_x;
    comp_t comp_y;
    comp_t comp_z;
    logic  done;
    logic  [PACKED_BITS-1:0] packed_code;
    logic  zero_vector;

    normal_code_t next_code;
    normal_code_t pending_codes [$];
    int           mismatches = 0;
    int           quiet_cycles = 0;

    octahedral_normal_encoder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .comp_x      (comp_x),
        .comp_y      (comp_y),
        .comp_z      (comp_z),
        .done        (done),
        .packed_code (packed_code),
        .zero_vector (zero_vector)
    );

    always #5 clk = ~clk;

    function automatic longint signum(input longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic normal_code_t encode_octahedral(input comp_t cx, input comp_t cy,
                                                       input comp_t cz);
        normal_code_t r;
        longint x;
        longint y;
        longint z;
        longint ax;
        longint ay;
        longint s;
        longint fx;
        longint fy;
        longint mu;
        longint qx;
        longint qy;
        x  = cx;
        y  = cy;
        z  = cz;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        s  = ax + ay + ((z < 0) ? -z : z);
        mu = (longint'(1) << CODE_BITS) - 1;
        if (s == 0)
        begin
            r.code = '0;
            r.zero = 1'b1;
            return r;
        end
        if (z < 0)
        begin
            fx = (s - ay) * signum(x);
            fy = (s - ax) * signum(y);
            x  = fx;
            y  = fy;
        end
        // round half up: floor(((c+s)*mu + s) / 2s)
        qx = ((x + s) * mu + s) / (2 * s);
        qy = ((y + s) * mu + s) / (2 * s);
        r.code = PACKED_BITS'((qy << CODE_BITS) | qx);
        r.zero = 1'b0;
        return r;
    endfunction

    // checking, acceptance and watchdog in one process so the order within an edge is fixed
    always @(posedge clk)
    begin
        normal_code_t exp_code;
        if (done)
        begin
            if (pending_codes.size() == 0)
            begin
                $display("%0t: unexpected result packed_code=%h zero_vector=%b",
                         $time, packed_code, zero_vector);
                mismatches++;
            end
            else
            begin
                exp_code = pending_codes.pop_front();
                if (packed_code !== exp_code.code)
                begin
                    $display("%0t: packed_code expected %h actual %h",
                             $time, exp_code.code, packed_code);
                    mismatches++;
                end
                if (zero_vector !== exp_code.zero)
                begin
                    $display("%0t: zero_vector expected %b actual %b",
                             $time, exp_code.zero, zero_vector);
                    mismatches++;
                end
            end
        end
        if (start && !busy)
            pending_codes.push_back(next_code);
        if (done || (start && !busy))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_vector(input comp_t x, input comp_t y, input comp_t z,
                               input logic fixed, input normal_code_t fixed_code);
        normal_code_t exp_code;
        exp_code = fixed ? fixed_code : encode_octahedral(x, y, z);
        @(negedge clk);
        start     <= 1'b1;
        comp_x    <= x;
        comp_y    <= y;
        comp_z    <= z;
        next_code <= exp_code;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic sender_gap(input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic comp_t random_component(input int mode);
        comp_t edges [7] = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1,
                             16'sd32766, 16'sd32767};
        case (mode)
            0:       return comp_t'($urandom_range(6)) - comp_t'(3);
            1:       return edges[$urandom_range(6)];
            default: return comp_t'($urandom());
        endcase
    endfunction

    initial
    begin
        int idle_pct [3];
        int count;
        int mode;
        comp_t x;
        comp_t y;
        comp_t z;
        idle_pct  = '{9, 68, 0};
        rst_n     = 1'b0;
        start     = 1'b0;
        comp_x    = '0;
        comp_y    = '0;
        comp_z    = '0;
        next_code = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (vector_table[i])
        begin
            sender_gap(idle_pct[0]);
            send_vector(vector_table[i].x, vector_table[i].y, vector_table[i].z,
                        vector_table[i].fixed,
                        '{code: vector_table[i].code, zero: vector_table[i].zero});
        end

        // hold off until the pipeline has drained
        @(negedge clk);
        start <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);

        for (int p = 0; p < 3; p++)
        begin
            count = (p == 2) ? RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3) : RANDOM_ITEMS / 3;
            for (int n = 0; n < count; n++)
            begin
                mode = $urandom_range(9);
                if (mode < 2)
                begin
                    x = random_component(0);
                    y = random_component(0);
                    z = random_component(0);
                end
                else if (mode < 4)
                begin
                    x = random_component(1);
                    y = random_component(1);
                    z = random_component(1);
                end
                else
                begin
                    x = random_component(2);
                    y = random_component(2);
                    z = random_component(2);
                    // bias toward the lower hemisphere fold
                    if (mode >= 8 && z >= 0)
                        z = -z - comp_t'(1);
                end
                sender_gap(idle_pct[p]);
                send_vector(x, y, z, 1'b0, '0);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
